// ----- design/itpt_pkg.sv -----
`timescale 1ns / 1ps

package itpt_pkg;

    localparam logic [1:0] OP_UDEC = 2'd0;
    localparam logic [1:0] OP_SDEC = 2'd1;
    localparam logic [1:0] OP_LHEX = 2'd2;
    localparam logic [1:0] OP_UHEX = 2'd3;

    localparam int NUM_NIBBLES = 10;
    localparam int DD_STAGES   = 4;
    localparam int DD_BITS     = 8;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_UP_A  = 8'h41;

    typedef struct packed {
        logic [31:0] mag;
        logic [39:0] bcd;
        logic        neg;
        logic        hex;
        logic        upper;
        logic        left;
        logic [5:0]  width;
        logic [4:0]  prec;
    } conv_t;

    typedef struct packed {
        logic [39:0] word;
        logic        neg;
        logic        upper;
        logic        left;
        logic [4:0]  textlen;
        logic [5:0]  pad;
        logic [5:0]  total;
    } emit_t;

    function automatic logic [7:0] nibble_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        base = upper ? CH_UP_A : CH_LOW_A;
        if (d < 4'd10)
            return CH_ZERO + {4'd0, d};
        else
            return base + {4'd0, d} - 8'd10;
    endfunction

endpackage

// ----- design/itpt_dd_stage.sv -----
`timescale 1ns / 1ps

// eight double-dabble steps, bits taken MSB first
module itpt_dd_stage #(
    parameter int STAGE = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  itpt_pkg::conv_t in_item,
    output logic            in_ready,
    output logic            out_valid,
    output itpt_pkg::conv_t out_item,
    input  logic            out_ready
);

    logic            valid_reg;
    itpt_pkg::conv_t item_reg;
    itpt_pkg::conv_t item_next;

    always_comb
    begin
        logic [39:0] b;
        b = in_item.bcd;
        for (int j = 0; j < itpt_pkg::DD_BITS; j++)
        begin
            for (int n = 0; n < itpt_pkg::NUM_NIBBLES; n++)
            begin
                if (b[n*4 +: 4] >= 4'd5)
                    b[n*4 +: 4] = b[n*4 +: 4] + 4'd3;
            end
            b = {b[38:0], in_item.mag[31 - itpt_pkg::DD_BITS*STAGE - j]};
        end
        item_next     = in_item;
        item_next.bcd = b;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= item_next;
    end

endmodule

// ----- design/itpt_emit.sv -----
`timescale 1ns / 1ps

module itpt_emit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  itpt_pkg::emit_t in_item,
    output logic            in_ready,
    output logic [7:0]      character,
    output logic            last,
    output logic            strobe
);

    logic            active_reg;
    itpt_pkg::emit_t item_reg;
    logic [5:0]      k_reg;
    logic [7:0]      char_reg;
    logic            last_reg;
    logic            strobe_reg;

    logic            cur_last;
    logic            in_text;
    logic [5:0]      t;
    logic [5:0]      dp;
    logic [3:0]      digit;
    logic [7:0]      char_next;

    assign cur_last = (k_reg == item_reg.total - 6'd1);

    always_comb
    begin
        if (item_reg.left)
        begin
            in_text = k_reg < {1'b0, item_reg.textlen};
            t       = k_reg;
        end
        else
        begin
            in_text = k_reg >= item_reg.pad;
            t       = k_reg - item_reg.pad;
        end
        dp    = {1'b0, item_reg.textlen} - 6'd1 - t;
        digit = (dp < 6'(itpt_pkg::NUM_NIBBLES)) ? item_reg.word[dp[3:0]*4 +: 4] : 4'd0;
        if (!in_text)
            char_next = itpt_pkg::CH_SPACE;
        else if (item_reg.neg && t == 6'd0)
            char_next = itpt_pkg::CH_MINUS;
        else
            char_next = itpt_pkg::nibble_char(digit, item_reg.upper);
    end

    assign in_ready  = !active_reg || cur_last;
    assign character = char_reg;
    assign last      = last_reg;
    assign strobe    = strobe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            strobe_reg <= 1'b0;
            k_reg      <= 6'd0;
        end
        else
        begin
            strobe_reg <= active_reg;
            if (in_ready)
            begin
                active_reg <= in_valid;
                k_reg      <= 6'd0;
            end
            else
                k_reg <= k_reg + 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= active_reg && cur_last;
        if (in_ready && in_valid)
            item_reg <= in_item;
    end

endmodule

// ----- design/integer_to_padded_text.sv -----
`timescale 1ns / 1ps

// A taken item flows through the input, double-dabble, length and emitter registers.
// Throughput: one character per cycle; an item takes max(field width, text length)
// characters, 1 to 63, through that single output port.
// Up to six further items wait in the conversion pipeline; busy rises when it is full.
// Reset clears all valid bits and the strobe; no result is pending after reset.
module integer_to_padded_text #(
    parameter int MAX_WIDTH     = 63,
    parameter int MAX_PRECISION = 23
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] value,
    input  logic [1:0]  operation,
    input  logic        left_justify,
    input  logic [5:0]  field_width,
    input  logic [5:0]  precision,
    output logic [7:0]  character,
    output logic        last,
    output logic        strobe
);

    localparam int NS = itpt_pkg::DD_STAGES;

    logic            s1_valid_reg;
    itpt_pkg::conv_t s1_item_reg;
    itpt_pkg::conv_t s1_next;
    logic            s1_ready;
    logic            accept;

    logic            dd_valid [NS+1];
    itpt_pkg::conv_t dd_item  [NS+1];
    logic            dd_ready [NS+1];

    logic            s6_valid_reg;
    itpt_pkg::emit_t s6_item_reg;
    itpt_pkg::emit_t s6_next;
    logic            s6_ready;
    logic            emit_ready;

    assign accept = start && !busy;

    always_comb
    begin
        logic neg;
        neg             = (operation == itpt_pkg::OP_SDEC) && value[31];
        s1_next.mag     = neg ? (32'd0 - value) : value;
        s1_next.bcd     = 40'd0;
        s1_next.neg     = neg;
        s1_next.hex     = operation[1];
        s1_next.upper   = (operation == itpt_pkg::OP_UHEX);
        s1_next.left    = left_justify;
        s1_next.width   = (field_width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : field_width;
        s1_next.prec    = (precision > 6'(MAX_PRECISION)) ? 5'(MAX_PRECISION) : precision[4:0];
    end

    assign s1_ready = !s1_valid_reg || dd_ready[0];
    assign busy     = !s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_item_reg <= s1_next;
    end

    assign dd_valid[0] = s1_valid_reg;
    assign dd_item[0]  = s1_item_reg;
    assign dd_ready[NS] = s6_ready;

    for (genvar s = 0; s < NS; s++)
    begin : g_dd
        itpt_dd_stage #(.STAGE(s)) u_dd (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dd_valid[s]),
            .in_item   (dd_item[s]),
            .in_ready  (dd_ready[s]),
            .out_valid (dd_valid[s+1]),
            .out_item  (dd_item[s+1]),
            .out_ready (dd_ready[s+1])
        );
    end

    always_comb
    begin
        itpt_pkg::conv_t c;
        logic [39:0] word;
        logic [4:0]  ndig;
        logic [4:0]  plen;
        logic [4:0]  tlen;
        logic [4:0]  sgn;
        c    = dd_item[NS];
        word = c.hex ? {8'd0, c.mag} : c.bcd;
        ndig = 5'd1;
        for (int n = 1; n < itpt_pkg::NUM_NIBBLES; n++)
        begin
            if (word[n*4 +: 4] != 4'd0)
                ndig = 5'(n + 1);
        end
        sgn  = {4'd0, c.neg};
        plen = ndig;
        if (c.prec > sgn && (c.prec - sgn) > ndig)
            plen = c.prec - sgn;
        tlen = plen + sgn;
        s6_next.word    = word;
        s6_next.neg     = c.neg;
        s6_next.upper   = c.upper;
        s6_next.left    = c.left;
        s6_next.textlen = tlen;
        s6_next.pad     = (c.width > {1'b0, tlen}) ? (c.width - {1'b0, tlen}) : 6'd0;
        s6_next.total   = (c.width > {1'b0, tlen}) ? c.width : {1'b0, tlen};
    end

    assign s6_ready = !s6_valid_reg || emit_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_valid_reg <= 1'b0;
        else if (s6_ready)
            s6_valid_reg <= dd_valid[NS];
    end

    always_ff @(posedge clk)
    begin
        if (s6_ready && dd_valid[NS])
            s6_item_reg <= s6_next;
    end

    itpt_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s6_valid_reg),
        .in_item   (s6_item_reg),
        .in_ready  (emit_ready),
        .character (character),
        .last      (last),
        .strobe    (strobe)
    );

endmodule

// ----- design/itpt_checker.sv -----
`timescale 1ns / 1ps

module itpt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [7:0] character,
    input logic       last,
    input logic       strobe
);

    logic [3:0] open_reg;
    logic [3:0] open_next;

    always_comb
    begin
        open_next = open_reg;
        if (start && !busy)
            open_next = open_next + 4'd1;
        if (strobe && last)
            open_next = open_next - 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            open_reg <= 4'd0;
        else
            open_reg <= open_next;
    end

    a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n) last |-> strobe)
        else $error("last without strobe");

    a_contig: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe)
        else $error("gap inside a field");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> open_reg != 4'd0)
        else $error("character with no item outstanding");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n) open_reg <= 4'd8)
        else $error("too many items in flight");

    a_char_known: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> !$isunknown(character))
        else $error("unknown character on strobe");

endmodule

bind integer_to_padded_text itpt_checker u_itpt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .character (character),
    .last      (last),
    .strobe    (strobe)
);

// ----- bench/padded_text_checker.sv -----
`timescale 1ns / 1ps

module padded_text_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [31:0] value,
    input  logic [1:0]  operation,
    input  logic        left_justify,
    input  logic [5:0]  field_width,
    input  logic [5:0]  precision,
    input  logic [7:0]  character,
    input  logic        last,
    input  logic        strobe,
    output int          mismatch_count,
    output int          chars_pending,
    output int          items_seen,
    output int          chars_seen
);

    localparam int PREC_CAP = 23;

    typedef struct {
        logic [7:0] ch;
        logic       last_flag;
        int         item;
    } text_char_t;

    text_char_t expected_text[$];
    int errors  = 0;
    int n_items = 0;
    int n_chars = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        errors++;
    endtask

    function automatic void push_char(input logic [7:0] ch, input logic is_last);
        text_char_t tc;
        tc.ch        = ch;
        tc.last_flag = is_last;
        tc.item      = n_items;
        expected_text.push_back(tc);
    endfunction

    // Builds the digit string, zero pads to the clamped precision, then space pads.
    function automatic void format_field(input logic [31:0] v, input logic [1:0] op,
                                         input logic lj, input logic [5:0] fw,
                                         input logic [5:0] pr);
        logic [7:0]  digits[$];
        logic [31:0] mag;
        logic        neg;
        logic [3:0]  nib;
        int          prec_c;
        int          pad;
        int          total;
        int          k;

        prec_c = (pr > PREC_CAP) ? PREC_CAP : int'(pr);
        neg    = 1'b0;
        mag    = v;
        if (op == itpt_pkg::OP_LHEX || op == itpt_pkg::OP_UHEX)
        begin
            do
            begin
                nib = mag[3:0];
                if (nib < 4'd10)
                    digits.push_front(itpt_pkg::CH_ZERO + 8'(nib));
                else
                    digits.push_front(((op == itpt_pkg::OP_UHEX) ? itpt_pkg::CH_UP_A
                                                                 : itpt_pkg::CH_LOW_A)
                                      + 8'(nib) - 8'd10);
                mag = mag >> 4;
            end
            while (mag != 0);
        end
        else
        begin
            if (op == itpt_pkg::OP_SDEC && v[31])
            begin
                neg = 1'b1;
                mag = 32'd0 - v;
            end
            do
            begin
                digits.push_front(itpt_pkg::CH_ZERO + 8'(mag % 10));
                mag = mag / 10;
            end
            while (mag != 0);
        end
        while (digits.size() + int'(neg) < prec_c)
            digits.push_front(itpt_pkg::CH_ZERO);
        if (neg)
            digits.push_front(itpt_pkg::CH_MINUS);

        pad   = (int'(fw) > digits.size()) ? int'(fw) - digits.size() : 0;
        total = digits.size() + pad;
        k     = 0;
        if (!lj)
            for (int i = 0; i < pad; i++, k++)
                push_char(itpt_pkg::CH_SPACE, k + 1 == total);
        foreach (digits[i])
        begin
            push_char(digits[i], k + 1 == total);
            k++;
        end
        if (lj)
            for (int i = 0; i < pad; i++, k++)
                push_char(itpt_pkg::CH_SPACE, k + 1 == total);
    endfunction

    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n)
        begin
            if (strobe)
            begin
                if (expected_text.size() == 0)
                    report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                              character, last));
                else
                begin
                    want = expected_text.pop_front();
                    if (character !== want.ch)
                        report_mismatch($sformatf("item %0d: character 0x%02h, expected 0x%02h",
                                                  want.item, character, want.ch));
                    if (last !== want.last_flag)
                        report_mismatch($sformatf("item %0d: last %0b, expected %0b",
                                                  want.item, last, want.last_flag));
                    n_chars++;
                end
            end
            if (start && !busy)
            begin
                format_field(value, operation, left_justify, field_width, precision);
                n_items++;
            end
        end
        mismatch_count <= errors;
        chars_pending  <= expected_text.size();
        items_seen     <= n_items;
        chars_seen     <= n_chars;
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] value;
    logic [1:0]  operation;
    logic        left_justify;
    logic [5:0]  field_width;
    logic [5:0]  precision;
    logic [7:0]  character;
    logic        last;
    logic        strobe;
    logic        idle_on;

    int mismatch_count;
    int chars_pending;
    int items_seen;
    int chars_seen;

    integer_to_padded_text DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .operation    (operation),
        .left_justify (left_justify),
        .field_width  (field_width),
        .precision    (precision),
        .character    (character),
        .last         (last),
        .strobe       (strobe)
    );

    padded_text_checker text_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .value          (value),
        .operation      (operation),
        .left_justify   (left_justify),
        .field_width    (field_width),
        .precision      (precision),
        .character      (character),
        .last           (last),
        .strobe         (strobe),
        .mismatch_count (mismatch_count),
        .chars_pending  (chars_pending),
        .items_seen     (items_seen),
        .chars_seen     (chars_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("timeout");
        $display("integer_to_padded_text verification failed");
        $finish;
    end

    task automatic send_item(input logic [31:0] v, input logic [1:0] op, input logic lj,
                             input logic [5:0] fw, input logic [5:0] pr);
        while (idle_on && $urandom_range(0, 99) < 14)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start        <= 1'b1;
        value        <= v;
        operation    <= op;
        left_justify <= lj;
        field_width  <= fw;
        precision    <= pr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        unique case ($urandom_range(0, 5))
            0: return 32'($urandom_range(0, 20));
            1: return 32'($urandom_range(0, 99999));
            2: return 32'h8000_0000 + 32'($urandom_range(0, 3));
            3: return 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
            4: return $urandom() >> $urandom_range(0, 31);
            default: return $urandom();
        endcase
    endfunction

    initial
    begin
        logic [5:0] fw;
        logic [5:0] pr;

        rst_n        = 1'b0;
        start        = 1'b0;
        value        = '0;
        operation    = itpt_pkg::OP_UDEC;
        left_justify = 1'b0;
        field_width  = '0;
        precision    = '0;
        idle_on      = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero value, with and without precision
        send_item(32'd0,          itpt_pkg::OP_UDEC, 1'b0, 6'd0,  6'd0);
        send_item(32'd0,          itpt_pkg::OP_LHEX, 1'b0, 6'd0,  6'd0);
        send_item(32'd0,          itpt_pkg::OP_SDEC, 1'b1, 6'd4,  6'd0);
        send_item(32'd0,          itpt_pkg::OP_UHEX, 1'b1, 6'd63, 6'd23);
        // extremes of the value
        send_item(32'hFFFF_FFFF,  itpt_pkg::OP_UDEC, 1'b0, 6'd0,  6'd0);
        send_item(32'hFFFF_FFFF,  itpt_pkg::OP_SDEC, 1'b0, 6'd0,  6'd0);
        send_item(32'h8000_0000,  itpt_pkg::OP_SDEC, 1'b0, 6'd0,  6'd0);
        send_item(32'h8000_0000,  itpt_pkg::OP_UDEC, 1'b0, 6'd0,  6'd0);
        send_item(32'h8000_0000,  itpt_pkg::OP_SDEC, 1'b1, 6'd40, 6'd63);
        send_item(32'h7FFF_FFFF,  itpt_pkg::OP_SDEC, 1'b0, 6'd12, 6'd0);
        send_item(32'hDEAD_BEEF,  itpt_pkg::OP_LHEX, 1'b0, 6'd10, 6'd0);
        send_item(32'hDEAD_BEEF,  itpt_pkg::OP_UHEX, 1'b1, 6'd10, 6'd0);
        send_item(32'hABCD_EF01,  itpt_pkg::OP_UHEX, 1'b0, 6'd63, 6'd63);
        // precision clamp and sign counted in precision
        send_item(32'd123,        itpt_pkg::OP_UDEC, 1'b0, 6'd0,  6'd40);
        send_item(-32'sd42,       itpt_pkg::OP_SDEC, 1'b0, 6'd0,  6'd5);
        send_item(-32'sd7,        itpt_pkg::OP_SDEC, 1'b1, 6'd10, 6'd3);
        send_item(32'hFFFF_FFFF,  itpt_pkg::OP_LHEX, 1'b1, 6'd0,  6'd23);
        // widest field, text longer than field, text exactly the field
        send_item(32'd5,          itpt_pkg::OP_UDEC, 1'b1, 6'd63, 6'd0);
        send_item(32'd5,          itpt_pkg::OP_UDEC, 1'b0, 6'd63, 6'd1);
        send_item(32'd1234567890, itpt_pkg::OP_UDEC, 1'b0, 6'd3,  6'd0);
        send_item(32'd12345,      itpt_pkg::OP_UDEC, 1'b1, 6'd5,  6'd0);
        send_item(32'h0000_00FF,  itpt_pkg::OP_LHEX, 1'b0, 6'd2,  6'd2);

        for (int n = 0; n < 250; n++)
        begin
            idle_on = (n < 60) || (n >= 140);
            fw = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                             : 6'($urandom_range(0, 24));
            pr = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                             : 6'($urandom_range(0, 12));
            send_item(pick_value(), 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      fw, pr);
        end
        start <= 1'b0;
        idle_on = 1'b1;

        @(posedge clk);
        while (chars_pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        $display("Run covered %0d items and %0d characters across all four formats,",
                 items_seen, chars_seen);
        $display("both justifications, widths to 63 and precisions past the clamp.");
        if (mismatch_count == 0)
            $display("integer_to_padded_text verification clean");
        else
            $display("integer_to_padded_text verification failed");
        $finish;
    end

endmodule
